@@ rtl/core/differential_drive_speed_mixer_defines.svh @@
// ----------------------------------------------------------------------------
// differential drive speed mixer assertion macros
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_SPEED_MIXER_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_SPEED_MIXER_DEFINES_SVH

`ifndef ASSERT_OFF
`define DDSM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ddsm assertion failed");
`define DDSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddsm assertion failed");
`else
`define DDSM_ASSERT(label, clk, rst_n, prop)
`define DDSM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/ddsm_pkg.sv @@
// ----------------------------------------------------------------------------
// ddsm_pkg
// Types, constants and the percent to motor byte mapping of the speed mixer.
// ----------------------------------------------------------------------------
package ddsm_pkg;

    localparam int FRACTION_BITS_DEF = 10;
    localparam int TRACK_BITS        = 10;
    localparam int SPEED_W           = 16;
    localparam int GAIN_W            = 8;
    localparam int OFFSET_W          = 7;
    localparam int TIMEOUT_W         = 16;
    localparam int AGE_W             = TIMEOUT_W + 1;
    localparam int MIX_W             = SPEED_W + TRACK_BITS + 1;
    localparam int MAG_W             = MIX_W - 1;
    localparam int PROD_W            = MAG_W + GAIN_W;
    localparam int MUL_B_W           = TRACK_BITS + 1;
    localparam int MUL_P_W           = MIX_W + MUL_B_W;
    localparam int CFG_INDEX_W       = 4;
    localparam int CFG_DATA_W        = 16;

    localparam logic [TRACK_BITS-1:0] HALF_TRACK_RESET = 10'd205;
    localparam logic [GAIN_W-1:0]     GAIN_RESET       = 8'd90;
    localparam logic [OFFSET_W-1:0]   OFFSET_RESET     = 7'd8;
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET    = 16'd1000;
    localparam logic [AGE_W-1:0]      AGE_RESET        = {1'b0, TIMEOUT_RESET} + 17'd1;

    localparam int PERCENT_LIMIT = 100;

    localparam logic [7:0] PERCENT_BIAS = 8'd100;
    localparam logic [7:0] SNAP_LOW     = 8'd126;
    localparam logic [7:0] SNAP_HIGH    = 8'd130;
    localparam logic [7:0] STOP_BYTE    = 8'd128;

    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_TRACK = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN       = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT    = 4'd3;

    typedef enum logic [1:0] {
        OP_COMMAND = 2'd0,
        OP_TICK    = 2'd1,
        OP_UPDATE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        MUL_TRACK,
        MUL_LEFT,
        MUL_RIGHT
    } mul_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TRACK,
        S_MIX,
        S_SCALE_L,
        S_FIN_L,
        S_SCALE_R,
        S_FIN_R,
        S_GATE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]                opcode;
        logic signed [SPEED_W-1:0] linear_speed;
        logic signed [SPEED_W-1:0] turn_rate;
        logic                      estop;
    } ddsm_in_t;

    typedef struct packed {
        logic [7:0]        left_drive;
        logic [7:0]        right_drive;
        logic signed [7:0] left_percent;
        logic signed [7:0] right_percent;
    } ddsm_out_t;

    typedef struct packed {
        logic     latch_in;
        logic     age_tick;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     mix_en;
        logic     fin_left;
        logic     fin_right;
        logic     gate_en;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       estop;
        logic       out_free;
    } dp_status_t;

    // floor((p + 100) * 255 / 200) as floor(floor(x * 51 / 8) / 5),
    // the divide by 5 done with a reciprocal of 1639 / 2^13
    function automatic logic [7:0] percent_to_byte(logic [7:0] pct);
        logic [7:0]  x;
        logic [13:0] x51;
        logic [10:0] z;
        logic [21:0] q;
        logic [7:0]  b;
        x   = pct + PERCENT_BIAS;
        x51 = ({6'd0, x} << 5) + ({6'd0, x} << 4) + ({6'd0, x} << 1) + {6'd0, x};
        z   = x51[13:3];
        q   = {11'd0, z} * 22'd1639;
        b   = q[20:13];
        if (b inside {[SNAP_LOW:SNAP_HIGH]}) begin
            b = STOP_BYTE;
        end
        return b;
    endfunction

endpackage

@@ rtl/core/differential_drive_speed_mixer.sv @@
// ----------------------------------------------------------------------------
// differential_drive_speed_mixer
// Turns velocity commands into left and right motor drive bytes.
// ----------------------------------------------------------------------------
// Input beats (s_*) carry an opcode: a velocity command mixes forward speed
// and turn rate into stored left/right percentages, a tick ages the command,
// and a drive update returns one result beat (m_*) with the gated percents
// and their motor bytes. Commands and ticks return nothing.
// The cfg_* channel writes the four settings; it is always ready and should
// only be used while the block is idle.
// One beat is taken at a time, all work goes through a single shared
// multiplier stepped by the sequencer, which holds the input while a command
// is mixed and scaled, a tick decoded, or an update gated until m_valid.
// The result register frees the input side, so the next beat is taken while
// a result waits; if the receiver stalls, a second update waits in its last
// step until the pending beat is taken.
// Reset returns settings to defaults, clears the stored percents and marks
// the command as stale, so updates drive 128 until a command arrives.
// ----------------------------------------------------------------------------
module differential_drive_speed_mixer #(
    parameter int FRACTION_BITS = ddsm_pkg::FRACTION_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ddsm_pkg::ddsm_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ddsm_pkg::ddsm_out_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ddsm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ddsm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ddsm_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    ddsm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ddsm_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ rtl/core/ddsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ddsm_ctrl
// Sequencer of the speed mixer: accepts one beat and steps the datapath.
// ----------------------------------------------------------------------------
module ddsm_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ddsm_pkg::dp_status_t   status,
    output ddsm_pkg::ctrl_cmd_t    cmd
);
    import ddsm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_TRACK;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                case (status.opcode)
                    OP_COMMAND: begin
                        // a command under stop is dropped
                        state_next = status.estop ? S_IDLE : S_TRACK;
                    end
                    OP_TICK: begin
                        cmd.age_tick = 1'b1;
                        state_next   = S_IDLE;
                    end
                    OP_UPDATE: begin
                        state_next = S_GATE;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_TRACK: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TRACK;
                state_next  = S_MIX;
            end
            S_MIX: begin
                cmd.mix_en = 1'b1;
                state_next = S_SCALE_L;
            end
            S_SCALE_L: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LEFT;
                state_next  = S_FIN_L;
            end
            S_FIN_L: begin
                cmd.fin_left = 1'b1;
                state_next   = S_SCALE_R;
            end
            S_SCALE_R: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RIGHT;
                state_next  = S_FIN_R;
            end
            S_FIN_R: begin
                cmd.fin_right = 1'b1;
                state_next    = S_IDLE;
            end
            S_GATE: begin
                cmd.gate_en = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/ddsm_datapath.sv @@
// ----------------------------------------------------------------------------
// ddsm_datapath
// Registers, shared multiplier, mixing, gating and output beat register.
// ----------------------------------------------------------------------------
`include "differential_drive_speed_mixer_defines.svh"

module ddsm_datapath #(
    parameter int FRACTION_BITS = ddsm_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  ddsm_pkg::ddsm_in_t                    s_data,
    input  logic                                  cfg_valid,
    input  logic [ddsm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ddsm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  ddsm_pkg::ctrl_cmd_t                   cmd,
    output ddsm_pkg::dp_status_t                  status,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output ddsm_pkg::ddsm_out_t                   m_data
);
    import ddsm_pkg::*;

    localparam int SHIFT   = FRACTION_BITS + TRACK_BITS;
    localparam int TOTAL_W = ((PROD_W > OFFSET_W + SHIFT) ? PROD_W : OFFSET_W + SHIFT) + 1;
    localparam int WHOLE_W = TOTAL_W - SHIFT;

    // configuration
    logic [TRACK_BITS-1:0] half_track_reg;
    logic [GAIN_W-1:0]     gain_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [TIMEOUT_W-1:0]  timeout_reg;

    // item and working registers
    ddsm_in_t              in_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [MAG_W-1:0]      mag_l_reg;
    logic [MAG_W-1:0]      mag_r_reg;
    logic                  neg_l_reg;
    logic                  neg_r_reg;
    logic signed [7:0]     left_reg;
    logic signed [7:0]     right_reg;
    logic [AGE_W-1:0]      age_reg;
    logic [AGE_W-1:0]      age_next;
    logic signed [7:0]     gated_l_reg;
    logic signed [7:0]     gated_r_reg;
    ddsm_out_t             out_reg;
    logic                  out_valid_reg;

    logic signed [MIX_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [MIX_W-1:0]   v_ext;
    logic signed [MIX_W-1:0]   comp_ext;
    logic signed [MIX_W-1:0]   mix_l;
    logic signed [MIX_W-1:0]   mix_r;
    logic signed [MIX_W-1:0]   abs_l;
    logic signed [MIX_W-1:0]   abs_r;
    logic [MAG_W-1:0]          fin_mag;
    logic                      fin_neg;
    logic [TOTAL_W-1:0]        total;
    logic [WHOLE_W-1:0]        whole;
    logic [6:0]                clamped;
    logic signed [7:0]         side_pct;
    logic [AGE_W-1:0]          age_limit;
    logic                      drive_off;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_track_reg <= HALF_TRACK_RESET;
            gain_reg       <= GAIN_RESET;
            offset_reg     <= OFFSET_RESET;
            timeout_reg    <= TIMEOUT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_HALF_TRACK: half_track_reg <= cfg_data[TRACK_BITS-1:0];
                CFG_GAIN:       gain_reg       <= cfg_data[GAIN_W-1:0];
                CFG_OFFSET:     offset_reg     <= cfg_data[OFFSET_W-1:0];
                CFG_TIMEOUT:    timeout_reg    <= cfg_data[TIMEOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // shared multiplier: turn rate by half track, then each side by the gain
    always_comb begin
        case (cmd.mul_sel)
            MUL_TRACK: begin
                mul_a = MIX_W'(in_reg.turn_rate);
                mul_b = {1'b0, half_track_reg};
            end
            MUL_LEFT: begin
                mul_a = {1'b0, mag_l_reg};
                mul_b = {{(MUL_B_W - GAIN_W){1'b0}}, gain_reg};
            end
            MUL_RIGHT: begin
                mul_a = {1'b0, mag_r_reg};
                mul_b = {{(MUL_B_W - GAIN_W){1'b0}}, gain_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // mixing, the compensation term sits in the low bits of the product
    always_comb begin
        v_ext    = {in_reg.linear_speed[SPEED_W-1], in_reg.linear_speed, {TRACK_BITS{1'b0}}};
        comp_ext = {prod_reg[MAG_W-1], prod_reg[MAG_W-1:0]};
        mix_l    = v_ext - comp_ext;
        mix_r    = v_ext + comp_ext;
        abs_l    = mix_l[MIX_W-1] ? -mix_l : mix_l;
        abs_r    = mix_r[MIX_W-1] ? -mix_r : mix_r;
    end

    // scale plus start offset, truncate toward zero, clamp
    always_comb begin
        fin_mag = cmd.fin_right ? mag_r_reg : mag_l_reg;
        fin_neg = cmd.fin_right ? neg_r_reg : neg_l_reg;
        total   = TOTAL_W'(prod_reg) + (TOTAL_W'(offset_reg) << SHIFT);
        whole   = total[TOTAL_W-1:SHIFT];
        clamped = (whole > WHOLE_W'(PERCENT_LIMIT)) ? 7'(PERCENT_LIMIT) : whole[6:0];
        if (fin_mag == '0) begin
            side_pct = '0;
        end else if (fin_neg) begin
            side_pct = -$signed({1'b0, clamped});
        end else begin
            side_pct = $signed({1'b0, clamped});
        end
    end

    always_comb begin
        age_limit = {1'b0, timeout_reg} + AGE_W'(1);
        age_next  = age_reg;
        if (cmd.age_tick) begin
            age_next = (age_reg >= age_limit) ? age_limit : age_reg + AGE_W'(1);
        end
        if (cmd.fin_right) begin
            age_next = '0;
        end
        drive_off = in_reg.estop || (age_reg > {1'b0, timeout_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg      <= '0;
            right_reg     <= '0;
            age_reg       <= AGE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            age_reg <= age_next;
            if (cmd.fin_left) begin
                left_reg <= side_pct;
            end
            if (cmd.fin_right) begin
                right_reg <= side_pct;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            in_reg <= s_data;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_p[PROD_W-1:0];
        end
        if (cmd.mix_en) begin
            mag_l_reg <= abs_l[MAG_W-1:0];
            mag_r_reg <= abs_r[MAG_W-1:0];
            neg_l_reg <= mix_l[MIX_W-1];
            neg_r_reg <= mix_r[MIX_W-1];
        end
        if (cmd.gate_en) begin
            gated_l_reg <= drive_off ? 8'sd0 : left_reg;
            gated_r_reg <= drive_off ? 8'sd0 : right_reg;
        end
        if (cmd.out_load) begin
            out_reg.left_drive    <= percent_to_byte(gated_l_reg);
            out_reg.right_drive   <= percent_to_byte(gated_r_reg);
            out_reg.left_percent  <= gated_l_reg;
            out_reg.right_percent <= gated_r_reg;
        end
    end

    assign status.opcode   = in_reg.opcode;
    assign status.estop    = in_reg.estop;
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `DDSM_ASSERT_NEXT(a_load_shows_beat, aclk, aresetn, cmd.out_load, out_valid_reg)
    `DDSM_ASSERT_NEXT(a_command_fresh, aclk, aresetn, cmd.fin_right, age_reg == '0)
    `DDSM_ASSERT(a_left_in_range, aclk, aresetn, (left_reg >= -8'sd100) && (left_reg <= 8'sd100))
    `DDSM_ASSERT_NEXT(a_stop_zeroes, aclk, aresetn, cmd.gate_en && in_reg.estop, (gated_l_reg == '0) && (gated_r_reg == '0))

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: differential drive speed mixer testbench
// Drives command, tick and update beats with bursty valid and a stalling
// receiver. Every update result is checked field by field against the typed
// row value or the in-bench mixer predictor, across several register settings.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ddsm_pkg::*;

    localparam logic [1:0]             OP_UNUSED    = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 4'd15;
    localparam int                     MIX_SHIFT    = FRACTION_BITS_DEF + TRACK_BITS;
    localparam int                     ITEMS_PER_PHASE = 244;
    localparam int                     NUM_PHASES      = 8;

    typedef struct {
        ddsm_in_t  beat;
        bit        typed;
        ddsm_out_t want;
    } drive_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    ddsm_in_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    ddsm_out_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // predictor copy of the settings and the mixer state
    int               half_track;
    int               gain_pct;
    int               offset_pct;
    logic [AGE_W-1:0] timeout_ms;
    int               cmd_left_pct;
    int               cmd_right_pct;
    logic [AGE_W-1:0] cmd_age;

    ddsm_out_t  drive_expect[$];
    drive_row_t directed_rows[$];
    ddsm_out_t  want;
    int         fault_count = 0;
    int         burst_left  = 0;

    differential_drive_speed_mixer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // scale one mixed side to a whole percent
    function automatic int wheel_percent(longint mixed);
        longint mag;
        longint total;
        longint whole;
        if (mixed == 0) begin
            return 0;
        end
        mag   = (mixed < 0) ? -mixed : mixed;
        total = mag * gain_pct + (longint'(offset_pct) << MIX_SHIFT);
        whole = total >>> MIX_SHIFT;
        if (whole > PERCENT_LIMIT) begin
            whole = PERCENT_LIMIT;
        end
        return (mixed < 0) ? -int'(whole) : int'(whole);
    endfunction

    function automatic logic [7:0] motor_byte(int pct);
        int b;
        b = (pct + PERCENT_LIMIT) * 255 / 200;
        if (b >= SNAP_LOW && b <= SNAP_HIGH) begin
            b = STOP_BYTE;
        end
        return b[7:0];
    endfunction

    // advance the predictor by one accepted beat, queue any result
    task automatic predict_drive(ddsm_in_t beat, bit typed, ddsm_out_t typed_want);
        longint           fwd;
        longint           turn;
        int               lp;
        int               rp;
        logic [AGE_W-1:0] age_limit;
        ddsm_out_t        res;
        age_limit = timeout_ms + 1'b1;
        case (beat.opcode)
            OP_COMMAND: begin
                if (!beat.estop) begin
                    fwd  = longint'(beat.linear_speed) * (longint'(1) << TRACK_BITS);
                    turn = longint'(beat.turn_rate) * half_track;
                    cmd_left_pct  = wheel_percent(fwd - turn);
                    cmd_right_pct = wheel_percent(fwd + turn);
                    cmd_age = '0;
                end
            end
            OP_TICK: begin
                cmd_age = (cmd_age >= age_limit) ? age_limit : cmd_age + 1'b1;
            end
            OP_UPDATE: begin
                lp = cmd_left_pct;
                rp = cmd_right_pct;
                if (beat.estop || cmd_age > timeout_ms) begin
                    lp = 0;
                    rp = 0;
                end
                res.left_drive    = motor_byte(lp);
                res.right_drive   = motor_byte(rp);
                res.left_percent  = lp[7:0];
                res.right_percent = rp[7:0];
                drive_expect.push_back(typed ? typed_want : res);
            end
            default: begin
            end
        endcase
    endtask

    // one input beat, with bursty valid
    task automatic send_beat(ddsm_in_t beat, bit typed, ddsm_out_t typed_want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        predict_drive(beat, typed, typed_want);
    endtask

    // wait out results and any command still in the pipe
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        while (drive_expect.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, int value);
        logic [CFG_DATA_W-1:0] data;
        data = value[CFG_DATA_W-1:0];
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_HALF_TRACK: half_track = int'(data[TRACK_BITS-1:0]);
            CFG_GAIN:       gain_pct   = int'(data[GAIN_W-1:0]);
            CFG_OFFSET:     offset_pct = int'(data[OFFSET_W-1:0]);
            CFG_TIMEOUT:    timeout_ms = {1'b0, data[TIMEOUT_W-1:0]};
            default: begin
            end
        endcase
    endtask

    task automatic program_settings(int ht, int g, int off, int tmo, bit poke_unmapped);
        put_reg(CFG_HALF_TRACK, ht);
        put_reg(CFG_GAIN, g);
        put_reg(CFG_OFFSET, off);
        put_reg(CFG_TIMEOUT, tmo);
        if (poke_unmapped) begin
            put_reg(CFG_UNMAPPED, $urandom_range(0, 65535));
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] random_speed();
        int t;
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: begin
                t = int'($urandom_range(0, 6000)) - 3000;
                return t[15:0];
            end
            2: begin
                t = int'($urandom_range(0, 400)) - 200;
                return t[15:0];
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: return 16'h7fff;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    3: return 16'h0001;
                    default: return 16'hffff;
                endcase
            end
        endcase
    endfunction

    function automatic ddsm_in_t random_beat();
        ddsm_in_t b;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            b.opcode = OP_COMMAND;
        end else if (pick < 62) begin
            b.opcode = OP_TICK;
        end else if (pick < 95) begin
            b.opcode = OP_UPDATE;
        end else begin
            b.opcode = OP_UNUSED;
        end
        b.linear_speed = random_speed();
        b.turn_rate    = random_speed();
        b.estop        = ($urandom_range(0, 9) == 0);
        return b;
    endfunction

    task automatic add_row(logic [1:0] op, int v, int w, bit stop, bit typed,
                           int ld, int rd, int lp, int rp);
        drive_row_t row;
        row.beat.opcode        = op;
        row.beat.linear_speed  = v[15:0];
        row.beat.turn_rate     = w[15:0];
        row.beat.estop         = stop;
        row.typed              = typed;
        row.want.left_drive    = ld[7:0];
        row.want.right_drive   = rd[7:0];
        row.want.left_percent  = lp[7:0];
        row.want.right_percent = rp[7:0];
        directed_rows.push_back(row);
    endtask

    // receiver stalls, the stall mode changes after each random span
    initial begin
        int         mode;
        int         span;
        logic [7:0] stall_pat;
        stall_pat = 8'b1011_0010;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 300);
            repeat (span) begin
                @(posedge aclk);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ($urandom_range(0, 2) == 0);
                    default: begin
                        m_ready <= stall_pat[0];
                        stall_pat = {stall_pat[0], stall_pat[7:1]};
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (drive_expect.size() == 0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("unexpected result beat: %0d %0d %0d %0d",
                             m_data.left_drive, m_data.right_drive,
                             m_data.left_percent, m_data.right_percent);
                end
            end else begin
                want = drive_expect.pop_front();
                if (m_data.left_drive !== want.left_drive
                        || m_data.right_drive !== want.right_drive
                        || m_data.left_percent !== want.left_percent
                        || m_data.right_percent !== want.right_percent) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("drive mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 want.left_drive, want.right_drive,
                                 want.left_percent, want.right_percent,
                                 m_data.left_drive, m_data.right_drive,
                                 m_data.left_percent, m_data.right_percent);
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL differential_drive_speed_mixer");
        $finish;
    end

    initial begin
        ddsm_in_t beat;
        ddsm_out_t none;
        int ph;
        int n;
        int tmo;
        none = '0;
        half_track    = HALF_TRACK_RESET;
        gain_pct      = GAIN_RESET;
        offset_pct    = OFFSET_RESET;
        timeout_ms    = {1'b0, TIMEOUT_RESET};
        cmd_left_pct  = 0;
        cmd_right_pct = 0;
        cmd_age       = AGE_RESET;

        // stale after reset, full scale both ways, pure turns, stop cases
        add_row(OP_UPDATE,  0,      0,      0, 1, 128, 128, 0,    0);
        add_row(OP_COMMAND, 32767,  0,      0, 0, 0,   0,   0,    0);
        add_row(OP_UPDATE,  0,      0,      0, 1, 255, 255, 100,  100);
        add_row(OP_COMMAND, -32768, 0,      0, 0, 0,   0,   0,    0);
        add_row(OP_UPDATE,  0,      0,      0, 1, 0,   0,   -100, -100);
        add_row(OP_COMMAND, 0,      32767,  0, 0, 0,   0,   0,    0);
        add_row(OP_UPDATE,  0,      0,      0, 1, 0,   255, -100, 100);
        add_row(OP_COMMAND, 0,      -32768, 0, 0, 0,   0,   0,    0);
        add_row(OP_UPDATE,  0,      0,      0, 1, 255, 0,   100,  -100);
        add_row(OP_COMMAND, 0,      0,      0, 0, 0,   0,   0,    0);
        add_row(OP_UPDATE,  0,      0,      0, 1, 128, 128, 0,    0);
        add_row(OP_COMMAND, 32767,  0,      1, 0, 0,   0,   0,    0);
        add_row(OP_UPDATE,  0,      0,      0, 1, 128, 128, 0,    0);
        add_row(OP_COMMAND, 1024,   0,      0, 0, 0,   0,   0,    0);
        add_row(OP_UPDATE,  0,      0,      1, 1, 128, 128, 0,    0);
        add_row(OP_UPDATE,  0,      0,      0, 0, 0,   0,   0,    0);
        add_row(OP_TICK,    0,      0,      0, 0, 0,   0,   0,    0);
        add_row(OP_UNUSED,  -1,     -1,     1, 0, 0,   0,   0,    0);
        add_row(OP_UPDATE,  0,      0,      0, 0, 0,   0,   0,    0);
        add_row(OP_COMMAND, -1,     1,      0, 0, 0,   0,   0,    0);
        add_row(OP_UPDATE,  0,      0,      0, 0, 0,   0,   0,    0);
        add_row(OP_COMMAND, 32767,  -32768, 0, 0, 0,   0,   0,    0);
        add_row(OP_UPDATE,  0,      0,      0, 0, 0,   0,   0,    0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            case (ph)
                0: program_settings(1023, 255, 127, 65535, 0);
                1: program_settings(0, 0, 0, 0, 0);
                // zero gain, offset still applies to nonzero sides
                2: program_settings($urandom_range(0, 1023), 0, $urandom_range(1, 127),
                                    $urandom_range(1, 6), 1);
                default: begin
                    case ($urandom_range(0, 3))
                        0: tmo = $urandom_range(1, 6);
                        1: tmo = $urandom_range(7, 60);
                        2: tmo = TIMEOUT_RESET;
                        default: tmo = $urandom_range(0, 65535);
                    endcase
                    program_settings($urandom_range(0, 1023), $urandom_range(0, 255),
                                     $urandom_range(0, 127), tmo, (ph == 5));
                end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                beat = random_beat();
                send_beat(beat, 0, none);
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        if (fault_count == 0 && drive_expect.size() == 0) begin
            $display("PASS differential_drive_speed_mixer");
        end else begin
            $display("FAIL differential_drive_speed_mixer");
        end
        $finish;
    end

endmodule
